@@ rtl/core/rational_arithmetic_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Shared concurrent assertion forms; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define RAU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared types, codes and widths.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int MAG_W = 64;
    localparam int CNT_W = $clog2(MAG_W);

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } smag_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_ADD,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_FINISH
    } state_t;

    function automatic smag_t to_smag(input logic [MAG_W-1:0] x);
        smag_t v;
        v.neg = x[MAG_W-1];
        v.mag = x[MAG_W-1] ? (~x + MAG_W'(1)) : x;
        return v;
    endfunction

endpackage

@@ rtl/core/rau_divider.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_divider
    import rau_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [MAG_W-1:0] dividend,
    input  logic [MAG_W-1:0] divisor,
    output logic             done,
    output logic [MAG_W-1:0] quotient
);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [MAG_W-1:0] rem_reg;
    logic [MAG_W-1:0] quo_reg;
    logic [MAG_W-1:0] div_reg;
    logic             done_reg;

    logic [MAG_W:0]   rem_sh;
    logic [MAG_W:0]   diff;

    assign rem_sh = {rem_reg, quo_reg[MAG_W-1]};
    assign diff   = rem_sh - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MAG_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[MAG_W])
            begin
                rem_reg <= diff[MAG_W-1:0];
                quo_reg <= {quo_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[MAG_W-1:0];
                quo_reg <= {quo_reg[MAG_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/core/rational_arithmetic_unit.sv @@
// Sequence: two cross products for multiply or divide, three for add or subtract, binary
// gcd steps, then two divisions by the gcd before the output beat.
// Flow: one beat in flight; next accept in the cycle after the output register loads.
// A zero denominator, divide by zero or operand overflow returns straight from the check
// state, a product or sum overflow from the sum state, skipping the gcd and divisions.
// Reset: rst_n asynchronous, active low; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Add, subtract, multiply or divide two signed rationals and reduce by gcd.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_assert.svh"

module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int WORD_BITS = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode, left_num, left_den, right_num, right_den, zero pad
    input  logic [263:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_num, result_den, status, zero pad
    output logic [135:0] m_tdata
);

    localparam logic [MAG_W-1:0] POS_LIM = (MAG_W'(1) << (WORD_BITS - 1)) - MAG_W'(1);

    function automatic logic fits(input smag_t v);
        return v.mag <= POS_LIM + MAG_W'(v.neg);
    endfunction

    state_t state_reg, state_next;

    logic [1:0]       op_reg;
    smag_t            a_reg, b_reg, c_reg, d_reg;
    logic [1:0]       mi_reg;
    logic [1:0]       pj_reg;
    logic [127:0]     acc_reg;
    smag_t            p0_reg, p1_reg, p2_reg;
    logic             ovf_reg;
    smag_t            num_reg, den_reg;
    logic [MAG_W-1:0] u_reg, v_reg;
    logic [CNT_W-1:0] k_reg;
    logic [MAG_W-1:0] qn_reg;
    logic [63:0]      rn_reg;
    logic [62:0]      rd_reg;
    logic [1:0]       st_reg;
    logic             m_valid_reg;
    logic [135:0]     m_data_reg;

    // operand select and partial-product multiply
    smag_t            mx, my;
    logic [31:0]      xh, yh;
    logic [63:0]      pp;
    logic [127:0]     pp_sh;
    logic [127:0]     full;
    smag_t            prod;
    logic             prod_ok;

    always_comb
    begin
        unique case (mi_reg)
            2'd0:    begin mx = a_reg; my = (op_reg == OP_MUL) ? c_reg : d_reg; end
            2'd1:    begin mx = c_reg; my = b_reg; end
            default: begin mx = b_reg; my = (op_reg == OP_DIV) ? c_reg : d_reg; end
        endcase
        xh = pj_reg[0] ? mx.mag[63:32] : mx.mag[31:0];
        yh = pj_reg[1] ? my.mag[63:32] : my.mag[31:0];
        pp = {32'd0, xh} * {32'd0, yh};
        case ({1'b0, pj_reg[0]} + {1'b0, pj_reg[1]})
            2'd0:    pp_sh = {64'd0, pp};
            2'd1:    pp_sh = {32'd0, pp, 32'd0};
            default: pp_sh = {pp, 64'd0};
        endcase
        full     = acc_reg + pp_sh;
        prod.mag = full[63:0];
        prod.neg = (mx.neg ^ my.neg) && (full[63:0] != '0);
        prod_ok  = (full[127:64] == '0) && fits(prod);
    end

    // sign-magnitude sum
    smag_t            t2, sum;
    logic [MAG_W:0]   s_add;
    logic             sum_ok;

    always_comb
    begin
        t2 = p1_reg;
        if (op_reg == OP_SUB && p1_reg.mag != '0)
            t2.neg = ~p1_reg.neg;
        s_add  = {1'b0, p0_reg.mag} + {1'b0, t2.mag};
        sum_ok = 1'b1;
        if (p0_reg.neg == t2.neg)
        begin
            sum.mag = s_add[MAG_W-1:0];
            sum.neg = p0_reg.neg && (s_add[MAG_W-1:0] != '0);
            sum_ok  = !s_add[MAG_W];
        end
        else if (p0_reg.mag >= t2.mag)
        begin
            sum.mag = p0_reg.mag - t2.mag;
            sum.neg = p0_reg.neg && (p0_reg.mag != t2.mag);
        end
        else
        begin
            sum.mag = t2.mag - p0_reg.mag;
            sum.neg = t2.neg;
        end
        sum_ok = sum_ok && fits(sum);
    end

    // input decode
    smag_t            in_a, in_b, in_c, in_d;
    logic             zero_err;
    logic             in_ovf;

    assign in_a     = to_smag(s_tdata[65:2]);
    assign in_b     = to_smag(s_tdata[129:66]);
    assign in_c     = to_smag(s_tdata[193:130]);
    assign in_d     = to_smag(s_tdata[257:194]);
    assign zero_err = (b_reg.mag == '0) || (d_reg.mag == '0)
                   || (op_reg == OP_DIV && c_reg.mag == '0);
    assign in_ovf   = !(fits(a_reg) && fits(b_reg) && fits(c_reg) && fits(d_reg));

    // divider
    logic             div_start;
    logic             div_done;
    logic [MAG_W-1:0] div_q;
    logic [MAG_W-1:0] gcd_val;

    assign gcd_val   = v_reg << k_reg;
    assign div_start = (state_reg == S_GCD && u_reg == '0)
                    || (state_reg == S_DIVN && div_done);

    rau_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ((state_reg == S_GCD) ? num_reg.mag : den_reg.mag),
        .divisor  (gcd_val),
        .done     (div_done),
        .quotient (div_q)
    );

    // final normalize
    smag_t            fin_num;
    logic             fin_ok;

    always_comb
    begin
        fin_num.mag = qn_reg;
        fin_num.neg = (num_reg.neg ^ den_reg.neg) && (qn_reg != '0);
        fin_ok      = fits(fin_num) && (div_q <= POS_LIM) && (div_q != '0);
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_tvalid) state_next = S_CHECK;
            S_CHECK:  state_next = (zero_err || in_ovf) ? S_FINISH : S_MUL;
            S_MUL:    if (pj_reg == 2'd3 && mi_reg == 2'd2) state_next = S_ADD;
            S_ADD:    state_next = (ovf_reg || ((op_reg == OP_ADD || op_reg == OP_SUB)
                                                && !sum_ok)) ? S_FINISH : S_GCD;
            S_GCD:    if (u_reg == '0) state_next = S_DIVN;
            S_DIVN:   if (div_done) state_next = S_DIVD;
            S_DIVD:   if (div_done) state_next = S_FINISH;
            S_FINISH: if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE:  s_tready = 1'b1;
            default: s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_FINISH && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                op_reg  <= s_tdata[1:0];
                a_reg   <= in_a;
                b_reg   <= in_b;
                c_reg   <= in_c;
                d_reg   <= in_d;
                mi_reg  <= 2'd0;
                pj_reg  <= 2'd0;
                acc_reg <= '0;
                ovf_reg <= 1'b0;
            end
            S_CHECK:
            begin
                rn_reg <= '0;
                rd_reg <= 63'd1;
                st_reg <= zero_err ? ST_ZERO : ST_OVF;
            end
            S_MUL:
            begin
                pj_reg <= pj_reg + 2'd1;
                if (pj_reg == 2'd3)
                begin
                    acc_reg <= '0;
                    ovf_reg <= ovf_reg | !prod_ok;
                    case (mi_reg)
                        2'd0:    p0_reg <= prod;
                        2'd1:    p1_reg <= prod;
                        default: p2_reg <= prod;
                    endcase
                    mi_reg <= (mi_reg == 2'd0 && op_reg[1]) ? 2'd2 : mi_reg + 2'd1;
                end
                else
                begin
                    acc_reg <= full;
                end
            end
            S_ADD:
            begin
                num_reg <= op_reg[1] ? p0_reg : sum;
                den_reg <= p2_reg;
                u_reg   <= op_reg[1] ? p0_reg.mag : sum.mag;
                v_reg   <= p2_reg.mag;
                k_reg   <= '0;
                rn_reg  <= '0;
                rd_reg  <= 63'd1;
                st_reg  <= ST_OVF;
            end
            S_GCD:
            begin
                if (u_reg != '0)
                begin
                    if (!u_reg[0] && !v_reg[0])
                    begin
                        u_reg <= u_reg >> 1;
                        v_reg <= v_reg >> 1;
                        k_reg <= k_reg + CNT_W'(1);
                    end
                    else if (!u_reg[0])
                        u_reg <= u_reg >> 1;
                    else if (!v_reg[0])
                        v_reg <= v_reg >> 1;
                    else if (u_reg >= v_reg)
                        u_reg <= u_reg - v_reg;
                    else
                        v_reg <= v_reg - u_reg;
                end
            end
            S_DIVN:
            begin
                if (div_done)
                    qn_reg <= div_q;
            end
            S_DIVD:
            begin
                if (div_done)
                begin
                    if (fin_ok)
                    begin
                        rn_reg <= fin_num.neg ? (~qn_reg + MAG_W'(1)) : qn_reg;
                        rd_reg <= div_q[62:0];
                        st_reg <= ST_OK;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                    m_data_reg <= {7'd0, st_reg, rd_reg, rn_reg};
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `RAU_ASSERT_NOW(a_den_nonzero, m_tvalid, m_tdata[126:64] != '0, "zero result_den")
    `RAU_ASSERT_NOW(a_err_result, m_tvalid && m_tdata[128:127] != ST_OK,
        m_tdata[63:0] == '0 && m_tdata[126:64] == 63'd1, "error beat carries data")
    `RAU_ASSERT_NOW(a_gcd_v, state_reg == S_GCD, v_reg != '0, "gcd operand lost")
    `RAU_ASSERT_NEXT(a_accept, s_tvalid && s_tready, state_reg == S_CHECK,
        "accepted beat not checked")

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives operand beats with random gaps, predicts the reduced result of each
// beat and checks every output beat field by field against the oldest one.
// ----------------------------------------------------------------------------
module tb;
    import rau_pkg::*;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] ln;
        logic [63:0] ld;
        logic [63:0] rn;
        logic [63:0] rd;
    } operands_t;

    typedef struct {
        logic [63:0] num;
        logic [62:0] den;
        logic [1:0]  status;
    } quotient_t;

    localparam int WDOG_LIMIT = 20000;
    localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [263:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;

    operands_t pending_q[$];
    quotient_t expected_q[$];
    int        errors;
    int        wdog;
    int        send_gap;
    int        recv_gap;
    bit        hold_off;

    rational_arithmetic_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    function automatic bit fits_word(bit neg, logic [63:0] mag);
        return mag <= POS_MAX + (neg ? 64'd1 : 64'd0);
    endfunction

    function automatic bit prod(bit an, logic [63:0] am, bit bn, logic [63:0] bm,
                                output bit rn, output logic [63:0] rm);
        logic [127:0] p;
        p  = am * bm;
        rm = p[63:0];
        rn = (an != bn) && rm != 0;
        return p[127:64] == 0 && fits_word(rn, rm);
    endfunction

    function automatic quotient_t reduce_rational(operands_t it);
        quotient_t   r;
        bit          an, bn, cn, dn, n1, n2, nn, dnn, ok;
        logic [63:0] am, bm, cm, dm, m1, m2, nm, dmg, g, x, y, t;
        logic [64:0] s;
        r.num = 0;
        r.den = 1;
        r.status = ST_OK;
        an = it.ln[63]; am = an ? -it.ln : it.ln;
        bn = it.ld[63]; bm = bn ? -it.ld : it.ld;
        cn = it.rn[63]; cm = cn ? -it.rn : it.rn;
        dn = it.rd[63]; dm = dn ? -it.rd : it.rd;
        if (bm == 0 || dm == 0 || (it.op == OP_DIV && cm == 0))
        begin
            r.status = ST_ZERO;
            return r;
        end
        ok = 1;
        if (it.op == OP_ADD || it.op == OP_SUB)
        begin
            ok = prod(an, am, dn, dm, n1, m1) && prod(cn, cm, bn, bm, n2, m2);
            if (it.op == OP_SUB && m2 != 0)
                n2 = !n2;
            if (ok)
            begin
                if (n1 == n2)
                begin
                    s = m1 + m2;
                    ok = !s[64];
                    nm = s[63:0];
                    nn = n1 && nm != 0;
                end
                else if (m1 >= m2)
                begin
                    nm = m1 - m2;
                    nn = n1 && nm != 0;
                end
                else
                begin
                    nm = m2 - m1;
                    nn = n2;
                end
                ok = ok && fits_word(nn, nm);
            end
            ok = ok && prod(bn, bm, dn, dm, dnn, dmg);
        end
        else if (it.op == OP_MUL)
            ok = prod(an, am, cn, cm, nn, nm) && prod(bn, bm, dn, dm, dnn, dmg);
        else
            ok = prod(an, am, dn, dm, nn, nm) && prod(bn, bm, cn, cm, dnn, dmg);
        if (ok)
        begin
            x = nm;
            y = dmg;
            while (y != 0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            g = (x == 0) ? 64'd1 : x;
            nm = nm / g;
            dmg = dmg / g;
            nn = (nn != dnn) && nm != 0;
            ok = fits_word(nn, nm) && dmg <= POS_MAX && dmg != 0;
        end
        if (!ok)
            r.status = ST_OVF;
        else
        begin
            r.num = nn ? -nm : nm;
            r.den = dmg[62:0];
        end
        return r;
    endfunction

    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        case ($urandom_range(0, 5))
            0: w = {$urandom, $urandom};
            1: w = 64'(signed'($urandom_range(0, 40)) - 20);
            2: w = 64'($signed({$urandom} >> $urandom_range(0, 31)));
            3: w = {{32{1'b0}}, $urandom} >> $urandom_range(0, 31);
            4: w = -({{32{1'b0}}, $urandom} >> $urandom_range(0, 31));
            default: w = $urandom_range(0, 3) == 0 ? NEG_MIN : POS_MAX - $urandom_range(0, 2);
        endcase
        return w;
    endfunction

    task automatic add_item(logic [1:0] op, logic [63:0] ln, logic [63:0] ld,
                            logic [63:0] rn, logic [63:0] rd);
        operands_t it;
        it.op = op; it.ln = ln; it.ld = ld; it.rn = rn; it.rd = rd;
        pending_q.insert(pending_q.size(), it);
    endtask

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        logic [1:0] op;
        errors = 0;
        rst_n = 0;
        for (int k = 0; k < 4; k++)
        begin
            op = 2'(k);
            add_item(op, 64'd1, 64'd2, 64'd1, 64'd3);
            add_item(op, -64'd6, 64'd4, 64'd9, -64'd12);
        end
        add_item(OP_ADD, 64'd1, 64'd0, 64'd1, 64'd1);
        add_item(OP_MUL, 64'd1, 64'd1, 64'd1, 64'd0);
        add_item(OP_DIV, 64'd5, 64'd7, 64'd0, 64'd3);
        add_item(OP_SUB, 64'd3, 64'd5, 64'd3, 64'd5);
        add_item(OP_MUL, 64'd0, -64'd7, 64'd4, 64'd9);
        add_item(OP_MUL, POS_MAX, 64'd1, POS_MAX, 64'd1);
        add_item(OP_ADD, POS_MAX, 64'd1, POS_MAX, 64'd1);
        add_item(OP_DIV, NEG_MIN, 64'd1, 64'd1, 64'd1);
        add_item(OP_DIV, NEG_MIN, 64'd1, -64'd1, 64'd1);
        add_item(OP_MUL, NEG_MIN, 64'd1, 64'd1, 64'd1);
        add_item(OP_SUB, NEG_MIN, NEG_MIN, POS_MAX, POS_MAX);
        add_item(OP_DIV, 64'd1, NEG_MIN, 64'd1, 64'd1);
        add_item(OP_MUL, 64'd1, 64'h4000_0000_0000_0000, 64'd1, 64'd2);
        add_item(OP_MUL, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                 POS_MAX, NEG_MIN);
        for (int i = 0; i < 1350; i++)
        begin
            op = 2'($urandom_range(0, 3));
            add_item(op, rand_word(), rand_word(), rand_word(), rand_word());
        end
        repeat (9) @(posedge clk);
        rst_n <= 1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 0;
            s_tdata  <= '0;
            send_gap <= 0;
            hold_off <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_q.insert(expected_q.size(), reduce_rational(pending_q.pop_front()));
                if (pending_q.size() == 700)
                    hold_off <= 1;
            end
            if (hold_off && expected_q.size() == 0 && !(s_tvalid && s_tready))
                hold_off <= 0;
            if (!(s_tvalid && !s_tready))
            begin
                if (hold_off || (s_tvalid && s_tready && pending_q.size() == 700)
                    || pending_q.size() == 0)
                    s_tvalid <= 0;
                else if (send_gap > 0 && !(s_tvalid && s_tready))
                begin
                    s_tvalid <= 0;
                    send_gap <= send_gap - 1;
                end
                else if (s_tvalid && s_tready && $urandom_range(0, 1))
                begin
                    s_tvalid <= 0;
                    send_gap <= $urandom_range(0, 10);
                end
                else
                begin
                    s_tvalid <= 1;
                    s_tdata  <= {6'b0, pending_q[0].rd, pending_q[0].rn,
                                 pending_q[0].ld, pending_q[0].ln, pending_q[0].op};
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        quotient_t exp_r;
        if (!rst_n)
        begin
            m_tready <= 0;
            recv_gap <= 0;
            wdog     <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected beat %h", $time, m_tdata);
                    errors++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (m_tdata[63:0] !== exp_r.num)
                    begin
                        $display("%0t: result_num exp %h got %h", $time, exp_r.num,
                                 m_tdata[63:0]);
                        errors++;
                    end
                    if (m_tdata[126:64] !== exp_r.den)
                    begin
                        $display("%0t: result_den exp %h got %h", $time, exp_r.den,
                                 m_tdata[126:64]);
                        errors++;
                    end
                    if (m_tdata[128:127] !== exp_r.status)
                    begin
                        $display("%0t: status exp %0d got %0d", $time, exp_r.status,
                                 m_tdata[128:127]);
                        errors++;
                    end
                end
            end
            if (m_tready && !m_tvalid)
                m_tready <= 1;
            else if (recv_gap > 0)
            begin
                m_tready <= 0;
                recv_gap <= recv_gap - 1;
            end
            else if (m_tvalid && m_tready && $urandom_range(0, 1))
            begin
                m_tready <= 0;
                recv_gap <= $urandom_range(0, 10);
            end
            else
                m_tready <= 1;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                wdog <= 0;
            else
                wdog <= wdog + 1;
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (pending_q.size() != 0 || expected_q.size() != 0)
        begin
            @(posedge clk);
            if (wdog >= WDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
        repeat (500) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
